### rtl/core/eas_pkg.sv
// Package for the exponential angle smoother: fixed widths, derived datapath widths,
// register indexes and the request and response types of the shared modulo unit.
// No dependencies; every other file of the block depends on it.
package eas_pkg;

    function automatic int imax(input int x, input int y);
        return (x > y) ? x : y;
    endfunction

    localparam int FRAC_BITS    = 12;
    localparam int SAMPLE_WIDTH = 20;
    localparam int OUT_WIDTH    = 20;
    localparam int ACC_W        = 32;
    localparam int ALPHA_W      = 13;
    localparam int PER_W        = 19;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam int ONE     = 1 << FRAC_BITS;
    localparam int AW      = FRAC_BITS + 1;
    localparam int X0_W    = ACC_W - FRAC_BITS;
    localparam int LO_W    = imax(X0_W, PER_W) + 1;
    localparam int DIFF_W  = imax(SAMPLE_WIDTH, LO_W) + 1;
    localparam int WS_W    = imax(imax(LO_W, PER_W + 1) + 1, SAMPLE_WIDTH);
    localparam int MA_W    = imax(ACC_W, WS_W);
    localparam int MB_W    = AW + 1;
    localparam int MP_W    = MA_W + MB_W;
    localparam int NX_W    = imax(ACC_W, WS_W + AW) + 1;
    localparam int QW      = NX_W - FRAC_BITS;
    localparam int DIV_W   = imax(DIFF_W, QW);
    localparam int CNT_W   = $clog2(DIV_W + 1);

    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = ALPHA_W'(4096);
    localparam logic [PER_W-1:0]   PERIOD_RESET = PER_W'(4096);
    localparam logic [PER_W-1:0]   LIMIT_RESET  = PER_W'(4096);

    typedef enum logic [1:0] {
        REG_ALPHA  = 2'd0,
        REG_MODE   = 2'd1,
        REG_PERIOD = 2'd2,
        REG_LIMIT  = 2'd3
    } eas_reg_t;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [PER_W-1:0]        divisor;
    } eas_div_req_t;

    typedef struct packed {
        logic             done;
        logic [PER_W-1:0] rem;
    } eas_div_rsp_t;

endpackage

### rtl/core/eas_sample_if.sv
// Input channel of the exponential angle smoother: valid, ready and one sample.
// Depends on eas_pkg for the sample width.
interface eas_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [eas_pkg::SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### rtl/core/eas_result_if.sv
// Output channel of the exponential angle smoother: valid, ready and one filtered value.
// Depends on eas_pkg for the output width.
interface eas_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [eas_pkg::OUT_WIDTH-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

### rtl/core/eas_fmod.sv
// Shared floored-modulo unit of the smoother: restoring remainder, one dividend bit a cycle,
// then a sign-correction step. Depends on eas_pkg.
module eas_fmod (
    input  logic                  clk,
    input  logic                  rst_n,
    input  eas_pkg::eas_div_req_t req,
    output eas_pkg::eas_div_rsp_t rsp
);
    import eas_pkg::*;

    logic             busy_reg, busy_next;
    logic             fix_reg, fix_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] mag_reg, mag_next;
    logic [PER_W-1:0] rem_reg, rem_next;
    logic [PER_W-1:0] div_reg, div_next;
    logic             neg_reg, neg_next;
    logic [PER_W:0]   trial;
    logic [PER_W:0]   trial_sub;

    assign trial     = {rem_reg, mag_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            neg_next  = req.dividend[DIV_W-1];
            mag_next  = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, div_reg}) ? PER_W'(trial_sub) : PER_W'(trial);
            mag_next = {mag_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            if (neg_reg && (rem_reg != '0))
            begin
                rem_next = div_reg - rem_reg;
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < div_reg))
        else $error("Remainder is not below the divisor.");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> (!busy_reg && !fix_reg))
        else $error("Modulo unit started while still working.");

endmodule

### rtl/core/exponential_angle_smoother.sv
// Top level of the exponential angle smoother: APB register file, sequencer, shared
// multiplier and the shared floored-modulo unit. Depends on eas_pkg, eas_sample_if,
// eas_result_if and eas_fmod.
//
//   channel          | dir | payload                 | handshake
//   -----------------+-----+-------------------------+------------------------------
//   sample_stream    | in  | sample, signed 20 bits  | valid/ready
//   filtered_stream  | out | filtered, signed 20 bits| valid/ready, output register
//   APB              | in  | alpha, mode, period, lim| psel/penable/pwrite, pready=1
//
// Plain mode does two multiplies through the one multiplier and an add for each item.
// Angle mode adds two passes through the modulo unit, each skipped when its period or limit is zero,
// one for unwrapping the sample and one for wrapping the new average.
// After reset the accumulator is zero and the first item primes it; no clearing pass.
// A result waiting in the output register holds the sequencer in its last step only.
module exponential_angle_smoother (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eas_pkg::ADDR_W-1:0]    paddr,
    input  logic [eas_pkg::DATA_W-1:0]    pwdata,
    output logic [eas_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    eas_sample_if.sink                    sample_stream,
    eas_result_if.source                  filtered_stream
);
    import eas_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE       = 10'b0000000001,
        S_WRAP       = 10'b0000000010,
        S_WRAP_DIV   = 10'b0000000100,
        S_WRAP_WAIT  = 10'b0000001000,
        S_MUL1       = 10'b0000010000,
        S_MUL2       = 10'b0000100000,
        S_SUM        = 10'b0001000000,
        S_LIMIT      = 10'b0010000000,
        S_LIMIT_WAIT = 10'b0100000000,
        S_COMMIT     = 10'b1000000000
    } state_t;

    localparam int CW = imax(ALPHA_W, AW);
    localparam int YW = imax(X0_W, OUT_WIDTH);
    localparam logic signed [NX_W-1:0] ACC_MAX_X = NX_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [NX_W-1:0] ACC_MIN_X = NX_W'(-(64'sd1 <<< (ACC_W - 1)));
    localparam logic signed [YW-1:0]   Y_MAX = YW'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
    localparam logic signed [YW-1:0]   Y_MIN = YW'(-(64'sd1 <<< (OUT_WIDTH - 1)));

    function automatic logic signed [X0_W-1:0] trunc_one(input logic signed [ACC_W-1:0] v);
        logic [ACC_W:0] biased;
        biased = {v[ACC_W-1], v} + (v[ACC_W-1] ? (ACC_W+1)'(ONE - 1) : (ACC_W+1)'(0));
        return X0_W'(biased[ACC_W:FRAC_BITS]);
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [NX_W-1:0] v);
        if (v > ACC_MAX_X)
        begin
            return ACC_W'(ACC_MAX_X);
        end
        else if (v < ACC_MIN_X)
        begin
            return ACC_W'(ACC_MIN_X);
        end
        return ACC_W'(v);
    endfunction

    state_t                  state_reg, state_next;
    logic [ALPHA_W-1:0]      alpha_reg, alpha_next;
    logic                    mode_reg, mode_next;
    logic [PER_W-1:0]        period_reg, period_next;
    logic [PER_W-1:0]        limit_reg, limit_next;
    logic                    primed_reg, primed_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    out_valid_reg, out_valid_next;

    logic signed [WS_W-1:0]      s_reg, s_next;
    logic signed [LO_W-1:0]      lo_reg, lo_next;
    logic signed [MP_W-1:0]      prod_reg, prod_next;
    logic signed [NX_W-1:0]      t_reg, t_next;
    logic signed [NX_W-1:0]      nx_reg, nx_next;
    logic signed [OUT_WIDTH-1:0] filtered_reg, filtered_next;

    logic                    cfg_wr;
    eas_reg_t                reg_idx;
    logic                    in_fire;
    logic [CW-1:0]           alpha_w;
    logic [AW-1:0]           a_clamp;
    logic [AW-1:0]           one_minus_a;
    logic signed [NX_W-1:0]  prime_w;
    logic signed [X0_W-1:0]  x0;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  mul_p;
    logic signed [MP_W-1:0]  prod_bias;
    logic signed [ACC_W-1:0] acc_sat;
    logic signed [YW-1:0]    y_w;
    eas_div_req_t            div_req;
    eas_div_rsp_t            div_rsp;

    eas_fmod u_fmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = eas_reg_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        unique case (reg_idx)
            REG_ALPHA:  prdata = DATA_W'(alpha_reg);
            REG_MODE:   prdata = DATA_W'(mode_reg);
            REG_PERIOD: prdata = DATA_W'(period_reg);
            REG_LIMIT:  prdata = DATA_W'(limit_reg);
            default:    prdata = '0;
        endcase
    end

    assign sample_stream.ready    = (state_reg == S_IDLE);
    assign in_fire                = sample_stream.valid && sample_stream.ready;
    assign filtered_stream.valid  = out_valid_reg;
    assign filtered_stream.filtered = filtered_reg;

    assign alpha_w = CW'(alpha_reg);
    always_comb
    begin
        if (alpha_w == '0)
        begin
            a_clamp = AW'(1);
        end
        else if (alpha_w > CW'(ONE))
        begin
            a_clamp = AW'(ONE);
        end
        else
        begin
            a_clamp = AW'(alpha_w);
        end
    end
    assign one_minus_a = AW'(ONE) - a_clamp;

    assign prime_w   = NX_W'(sample_stream.sample) <<< FRAC_BITS;
    assign x0        = trunc_one(acc_reg);
    assign lo_next   = LO_W'(x0) - $signed(LO_W'(period_reg >> 1));
    assign mul_a     = (state_reg == S_MUL1) ? MA_W'(acc_reg) : MA_W'(s_reg);
    assign mul_b     = (state_reg == S_MUL1) ? $signed(MB_W'(one_minus_a))
                                              : $signed(MB_W'(a_clamp));
    assign mul_p     = mul_a * mul_b;
    assign prod_bias = prod_reg + MP_W'(prod_reg[MP_W-1] ? ONE - 1 : 0);
    assign acc_sat   = sat_acc(nx_reg);
    assign y_w       = YW'(trunc_one(acc_sat));

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        mode_next      = mode_reg;
        period_next    = period_reg;
        limit_next     = limit_reg;
        primed_next    = primed_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        s_next         = s_reg;
        prod_next      = prod_reg;
        t_next         = t_reg;
        nx_next        = nx_reg;
        filtered_next  = filtered_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(s_reg) - DIV_W'(lo_reg);
        div_req.divisor  = period_reg;

        if (out_valid_reg && filtered_stream.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    s_next      = WS_W'(sample_stream.sample);
                    primed_next = 1'b1;
                    if (!primed_reg)
                    begin
                        acc_next = sat_acc(prime_w);
                    end
                    state_next = (mode_reg && (period_reg != '0)) ? S_WRAP : S_MUL1;
                end
            end
            S_WRAP:
            begin
                state_next = S_WRAP_DIV;
            end
            S_WRAP_DIV:
            begin
                div_req.start = 1'b1;
                state_next    = S_WRAP_WAIT;
            end
            S_WRAP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    s_next     = WS_W'(lo_reg) + $signed(WS_W'(div_rsp.rem));
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                prod_next  = mul_p;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                t_next     = NX_W'(prod_bias >>> FRAC_BITS);
                prod_next  = mul_p;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                nx_next    = t_reg + NX_W'(prod_reg);
                state_next = S_LIMIT;
            end
            S_LIMIT:
            begin
                div_req.dividend = DIV_W'(nx_reg >>> FRAC_BITS);
                div_req.divisor  = limit_reg;
                if (mode_reg && (limit_reg != '0))
                begin
                    div_req.start = 1'b1;
                    state_next    = S_LIMIT_WAIT;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_LIMIT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    nx_next    = NX_W'({div_rsp.rem, nx_reg[FRAC_BITS-1:0]});
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || filtered_stream.ready)
                begin
                    acc_next       = acc_sat;
                    out_valid_next = 1'b1;
                    if (y_w > Y_MAX)
                    begin
                        filtered_next = OUT_WIDTH'(Y_MAX);
                    end
                    else if (y_w < Y_MIN)
                    begin
                        filtered_next = OUT_WIDTH'(Y_MIN);
                    end
                    else
                    begin
                        filtered_next = OUT_WIDTH'(y_w);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            primed_next = 1'b0;
            unique case (reg_idx)
                REG_ALPHA:  alpha_next  = pwdata[ALPHA_W-1:0];
                REG_MODE:   mode_next   = pwdata[0];
                REG_PERIOD: period_next = pwdata[PER_W-1:0];
                REG_LIMIT:  limit_next  = pwdata[PER_W-1:0];
                default:    primed_next = primed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alpha_reg     <= ALPHA_RESET;
            mode_reg      <= 1'b0;
            period_reg    <= PERIOD_RESET;
            limit_reg     <= LIMIT_RESET;
            primed_reg    <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            mode_reg      <= mode_next;
            period_reg    <= period_next;
            limit_reg     <= limit_next;
            primed_reg    <= primed_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        lo_reg       <= (state_reg == S_WRAP) ? lo_next : lo_reg;
        prod_reg     <= prod_next;
        t_reg        <= t_next;
        nx_reg       <= nx_next;
        filtered_reg <= filtered_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_stream.valid && sample_stream.ready) |=> !sample_stream.ready)
        else $error("A second item was taken while one is in progress.");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_WRAP_WAIT || state_reg == S_LIMIT_WAIT))
        else $error("Modulo result arrived outside a waiting step.");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filtered_stream.valid) |-> $past(state_reg == S_COMMIT))
        else $error("A result appeared without a commit step.");

endmodule
